@@ design/srfp_pkg.sv @@
// package for the serial range frame parser
// holds field types, phase codes, byte and result constants; no dependencies
`timescale 1ns / 1ps

package srfp_pkg;

    typedef logic [1:0]         mode_t;
    typedef logic [7:0]         byte_t;
    typedef logic [9:0]         limit_t;
    typedef logic signed [14:0] range_t;
    typedef logic [1:0]         status_t;
    typedef logic [0:0]         cfg_index_t;
    typedef logic [13:0]        value_t;
    typedef logic [2:0]         count_t;

    // input modes
    localparam mode_t MODE_START = 2'd0;
    localparam mode_t MODE_BYTE  = 2'd1;
    localparam mode_t MODE_TICK  = 2'd2;

    // configuration register indexes
    localparam cfg_index_t CFG_WAIT_LIMIT  = 1'd0;
    localparam cfg_index_t CFG_FRAME_LIMIT = 1'd1;

    // parser phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_FRAME = 2'd2;

    // result status codes
    localparam status_t ST_VALID   = 2'd0;
    localparam status_t ST_SENSOR  = 2'd1;
    localparam status_t ST_TIMEOUT = 2'd2;

    localparam byte_t  START_BYTE = 8'h52;
    localparam byte_t  CR_BYTE    = 8'd13;
    localparam byte_t  DIGIT_LO   = 8'd48;
    localparam byte_t  DIGIT_HI   = 8'd57;
    localparam count_t DIGITS     = 3'd4;

    localparam value_t ERR_CODE_SHORT = 14'd500;
    localparam value_t ERR_CODE_LONG  = 14'd5000;
    localparam range_t TIMEOUT_RANGE  = -15'sd9999;

    localparam limit_t WAIT_LIMIT_RESET  = 10'd200;
    localparam limit_t FRAME_LIMIT_RESET = 10'd20;
    localparam limit_t ELAPSED_MAX       = 10'h3FF;

    typedef struct packed {
        range_t  range_mm;
        status_t status;
    } result_t;

endpackage

@@ design/serial_range_frame_parser.sv @@
// Serial range frame parser: start commands, received bytes and millisecond ticks in,
// one signed range with status out per measurement. Takes one item every clock cycle;
// while in_stall is low; an item's result, if any, passes the input register, then the
// result register. A skid register behind the result register lets a transfer go in
// while a result is stalled; input stalls only when both output registers are full and
// an item is waiting. Limits are written through cfg_we/cfg_index/cfg_data, and the user
// must do so only while idle; the block does not enforce it. Depends on srfp_pkg
`timescale 1ns / 1ps

module serial_range_frame_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  srfp_pkg::cfg_index_t   cfg_index,
    input  srfp_pkg::limit_t       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  srfp_pkg::mode_t        mode,
    input  srfp_pkg::byte_t        rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output srfp_pkg::range_t       range_mm,
    output srfp_pkg::status_t      status
);
    import srfp_pkg::*;

    limit_t     wait_limit_reg;
    limit_t     frame_limit_reg;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    mode_t      s1_mode_reg;
    byte_t      s1_byte_reg;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    limit_t     elapsed_reg;
    limit_t     elapsed_next;
    count_t     count_reg;
    count_t     count_next;
    value_t     acc_reg;
    value_t     acc_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;
    result_t    out_next;
    logic       skid_full_reg;
    logic       skid_full_next;
    result_t    skid_reg;
    result_t    skid_next;

    logic       in_xfer;
    logic       proc;
    logic       res_valid;
    result_t    res;
    value_t     acc_sum;
    count_t     count_inc;
    limit_t     elapsed_inc;
    limit_t     limit_sel;
    logic       is_digit;
    logic       out_take;

    assign in_stall  = s1_valid_reg && skid_full_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign proc      = s1_valid_reg && !skid_full_reg;
    assign out_valid = out_valid_reg;
    assign range_mm  = out_reg.range_mm;
    assign status    = out_reg.status;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_limit_reg  <= WAIT_LIMIT_RESET;
            frame_limit_reg <= FRAME_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WAIT_LIMIT:  wait_limit_reg  <= cfg_data;
                CFG_FRAME_LIMIT: frame_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // parser step on the registered item
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        res_valid    = 1'b0;
        res          = '{range_mm: TIMEOUT_RANGE, status: ST_TIMEOUT};
        is_digit     = (s1_byte_reg >= DIGIT_LO) && (s1_byte_reg <= DIGIT_HI);
        // acc * 10 + digit, acc stays below 1000 before the last digit
        acc_sum      = value_t'({acc_reg, 3'b000}) + value_t'({acc_reg, 1'b0})
                       + value_t'(s1_byte_reg - DIGIT_LO);
        count_inc    = count_reg + 3'd1;
        elapsed_inc  = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 10'd1 : elapsed_reg;
        limit_sel    = (phase_reg == PH_FRAME) ? frame_limit_reg : wait_limit_reg;

        if (proc)
        begin
            unique case (s1_mode_reg)
                MODE_START:
                begin
                    phase_next   = PH_WAIT;
                    elapsed_next = '0;
                    count_next   = '0;
                    acc_next     = '0;
                end
                MODE_BYTE:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (s1_byte_reg == START_BYTE)
                        begin
                            phase_next   = PH_FRAME;
                            elapsed_next = '0;
                            count_next   = '0;
                            acc_next     = '0;
                        end
                    end
                    else if (phase_reg == PH_FRAME)
                    begin
                        if (is_digit)
                        begin
                            acc_next   = acc_sum;
                            count_next = count_inc;
                            if (count_inc >= DIGITS)
                            begin
                                res_valid = 1'b1;
                                if (acc_sum == ERR_CODE_SHORT || acc_sum == ERR_CODE_LONG)
                                begin
                                    res.range_mm = -range_t'({1'b0, acc_sum});
                                    res.status   = ST_SENSOR;
                                end
                                else
                                begin
                                    res.range_mm = range_t'({1'b0, acc_sum});
                                    res.status   = ST_VALID;
                                end
                            end
                        end
                        else if (s1_byte_reg == CR_BYTE)
                        begin
                            count_next = '0;
                            acc_next   = '0;
                        end
                    end
                end
                MODE_TICK:
                begin
                    if (phase_reg == PH_WAIT || phase_reg == PH_FRAME)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= limit_sel)
                            res_valid = 1'b1;
                    end
                end
                default: ;
            endcase

            // any result ends the measurement
            if (res_valid)
            begin
                phase_next   = PH_IDLE;
                elapsed_next = '0;
                count_next   = '0;
                acc_next     = '0;
            end
        end
    end

    // result register with skid stage behind it
    always_comb
    begin
        out_take       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        skid_full_next = skid_full_reg;
        skid_next      = skid_reg;
        if (out_take)
        begin
            if (skid_full_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = skid_reg;
                skid_full_next = 1'b0;
            end
            else if (proc && res_valid)
            begin
                out_valid_next = 1'b1;
                out_next       = res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (proc && res_valid)
        begin
            skid_full_next = 1'b1;
            skid_next      = res;
        end
    end

    assign s1_valid_next = in_xfer ? 1'b1 : (proc ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            count_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= rx_byte;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // skid only fills behind a stalled result
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid register full while result register empty");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (elapsed_reg == '0 && count_reg == '0 && acc_reg == '0))
        else $error("idle parser holds measurement state");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < DIGITS)
        else $error("digit count reached four without a result");

    a_timeout_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_TIMEOUT) |-> (out_reg.range_mm == TIMEOUT_RANGE))
        else $error("timeout result carries wrong range");

    a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && res_valid) |=> (phase_reg == PH_IDLE))
        else $error("parser not idle after a result");

endmodule

@@ tb/range_result_checker.sv @@
// checker for the serial range frame parser: watches the limit writes and both channels,
// predicts each range result and compares it field by field with what comes out
// depends on srfp_pkg
`timescale 1ns / 1ps

module range_result_checker
    import srfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  limit_t     cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  mode_t      mode,
    input  byte_t      rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  range_t     range_mm,
    input  status_t    status,
    output int         mismatch_count,
    output int         ranges_pending
);

    limit_t     wait_ms_limit  = WAIT_LIMIT_RESET;
    limit_t     frame_ms_limit = FRAME_LIMIT_RESET;
    logic [1:0] parse_phase    = PH_IDLE;
    limit_t     ticks_seen     = '0;
    count_t     digits_seen    = '0;
    value_t     reading        = '0;
    result_t    ranges_due[$];
    result_t    oldest;

    initial
    begin
        mismatch_count = 0;
        ranges_pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] range mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic clear_frame();
        ticks_seen  = '0;
        digits_seen = '0;
        reading     = '0;
    endtask

    task automatic close_measurement(input range_t r, input status_t s);
        result_t res;
        res.range_mm = r;
        res.status   = s;
        ranges_due.push_back(res);
        parse_phase = PH_IDLE;
        clear_frame();
    endtask

    task automatic step_parser(input mode_t m, input byte_t b);
        limit_t lim;
        case (m)
            MODE_START:
            begin
                // a start while busy drops the running measurement
                parse_phase = PH_WAIT;
                clear_frame();
            end
            MODE_BYTE:
            begin
                if (parse_phase == PH_WAIT)
                begin
                    if (b == START_BYTE)
                    begin
                        parse_phase = PH_FRAME;
                        clear_frame();
                    end
                end
                else if (parse_phase == PH_FRAME)
                begin
                    if (b >= DIGIT_LO && b <= DIGIT_HI)
                    begin
                        reading     = value_t'(reading * 10 + (b - DIGIT_LO));
                        digits_seen = digits_seen + 1'b1;
                        if (digits_seen >= DIGITS)
                        begin
                            if (reading == ERR_CODE_SHORT || reading == ERR_CODE_LONG)
                                close_measurement(-range_t'(reading), ST_SENSOR);
                            else
                                close_measurement(range_t'(reading), ST_VALID);
                        end
                    end
                    else if (b == CR_BYTE)
                    begin
                        digits_seen = '0;
                        reading     = '0;
                    end
                end
            end
            MODE_TICK:
            begin
                if (parse_phase != PH_IDLE)
                begin
                    lim = (parse_phase == PH_WAIT) ? wait_ms_limit : frame_ms_limit;
                    // elapsed count saturates rather than wrapping
                    if (ticks_seen != ELAPSED_MAX)
                        ticks_seen = ticks_seen + 1'b1;
                    if (ticks_seen >= lim)
                        close_measurement(TIMEOUT_RANGE, ST_TIMEOUT);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_ms_limit  = WAIT_LIMIT_RESET;
            frame_ms_limit = FRAME_LIMIT_RESET;
            parse_phase    = PH_IDLE;
            clear_frame();
            ranges_due.delete();
            ranges_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WAIT_LIMIT)
                    wait_ms_limit = cfg_data;
                else if (cfg_index == CFG_FRAME_LIMIT)
                    frame_ms_limit = cfg_data;
            end
            // results first, so a transfer in this cycle cannot pair with its own input
            if (out_valid && !out_stall)
            begin
                if (ranges_due.size() == 0)
                begin
                    report_mismatch($sformatf("range_mm %0d status %0d with nothing pending",
                                              range_mm, status));
                end
                else
                begin
                    oldest = ranges_due.pop_front();
                    if (range_mm !== oldest.range_mm)
                        report_mismatch($sformatf("range_mm %0d, expected %0d",
                                                  range_mm, oldest.range_mm));
                    if (status !== oldest.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, oldest.status));
                end
            end
            if (in_valid && !in_stall)
                step_parser(mode, rx_byte);
            ranges_pending = ranges_due.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// top of the serial range frame parser testbench: clock, reset, limit writes and stimulus
// drives measurements of every shape under several idling patterns and gives the verdict
// depends on srfp_pkg, serial_range_frame_parser and range_result_checker
`timescale 1ns / 1ps

module testbench;
    import srfp_pkg::*;

    localparam int    HALF_PERIOD = 10;
    localparam int    CYCLE_LIMIT = 400000;
    localparam int    MAX_READING = 9999;
    localparam int    PHASE_ITEMS = 60;
    localparam mode_t MODE_UNUSED = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    limit_t     cfg_data;
    logic       in_valid;
    logic       in_stall;
    mode_t      mode;
    byte_t      rx_byte;
    logic       out_valid;
    logic       out_stall = 1'b0;
    range_t     range_mm;
    status_t    status;

    int mismatch_count;
    int ranges_pending;
    int cycle_count = 0;
    int items_sent  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int cur_wait    = WAIT_LIMIT_RESET;
    int cur_frame   = FRAME_LIMIT_RESET;

    int     idle_tab[4]  = '{0, 70, 0, 14};
    int     stall_tab[4] = '{0, 0, 70, 14};
    limit_t wait_tab[7]  = '{1, 3, 10, 0, 40, 2, 200};
    limit_t frame_tab[7] = '{1, 7, 2, 5, 25, 0, 20};

    serial_range_frame_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .range_mm  (range_mm),
        .status    (status)
    );

    range_result_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .range_mm       (range_mm),
        .status         (status),
        .mismatch_count (mismatch_count),
        .ranges_pending (ranges_pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** serial_range_frame_parser: FAILED **");
            $finish;
        end
    end

    // called and returns at a falling edge; valid stays high into the next call
    task automatic send(input mode_t m, input byte_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            mode     <= mode_t'($urandom_range(3));
            rx_byte  <= byte_t'($urandom_range(255));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send(MODE_TICK, byte_t'($urandom_range(255)));
    endtask

    task automatic send_digit(input int d);
        send(MODE_BYTE, DIGIT_LO + byte_t'(d));
    endtask

    // drain: every expected result out, then a wait for items still in flight
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (ranges_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_limits(input limit_t w, input limit_t f);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WAIT_LIMIT;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= CFG_FRAME_LIMIT;
        cfg_data  <= f;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        cur_wait  = w;
        cur_frame = f;
    endtask

    // one measurement: start, filler, frame start, digits with filler, or a timeout,
    // or abandoned part way so the next start drops it, or only stray transfers
    task automatic run_measurement(input bit force_timeout);
        int    ticks;
        int    allowed;
        int    v;
        int    pos;
        int    n_dig;
        int    crs;
        int    abandon;
        int    digit[4];
        bit    timeout_wait;
        bit    timeout_frame;
        byte_t b;

        if (!force_timeout && $urandom_range(99) < 8)
        begin
            // stray transfers between measurements
            repeat ($urandom_range(3, 1))
                send(mode_t'($urandom_range(3, 1)), byte_t'($urandom_range(255)));
            return;
        end

        abandon       = ($urandom_range(99) < 6) ? $urandom_range(2, 1) : 0;
        timeout_wait  = force_timeout || (cur_wait <= 50 && $urandom_range(99) < 10);
        timeout_frame = cur_frame <= 50 && $urandom_range(99) < 10;

        send(MODE_START, byte_t'($urandom_range(255)));
        ticks   = 0;
        allowed = (cur_wait > 0) ? cur_wait - 1 : 0;
        repeat ($urandom_range(4))
        begin
            case ($urandom_range(3))
                0:
                begin
                    if (ticks < allowed)
                    begin
                        send_tick();
                        ticks++;
                    end
                end
                1:
                    send(MODE_UNUSED, byte_t'($urandom_range(255)));
                default:
                begin
                    b = byte_t'($urandom_range(255));
                    if (b == START_BYTE)
                        b = b ^ 8'h80;
                    send(MODE_BYTE, b);
                end
            endcase
        end
        if (abandon == 1)
            return;
        if (timeout_wait)
        begin
            while (ticks < ((cur_wait > 0) ? cur_wait : 1))
            begin
                send_tick();
                ticks++;
            end
            return;
        end

        send(MODE_BYTE, START_BYTE);
        case ($urandom_range(9))
            0:       v = ERR_CODE_SHORT;
            1:       v = ERR_CODE_LONG;
            2:       v = $urandom_range(1) ? 0 : MAX_READING;
            default: v = $urandom_range(MAX_READING);
        endcase
        digit[0] = v / 1000;
        digit[1] = (v / 100) % 10;
        digit[2] = (v / 10) % 10;
        digit[3] = v % 10;

        ticks   = 0;
        allowed = (cur_frame > 0) ? cur_frame - 1 : 0;
        n_dig   = (timeout_frame || abandon == 2) ? $urandom_range(3) : 4;
        pos     = 0;
        crs     = 0;
        while (pos < n_dig)
        begin
            case ($urandom_range(8))
                0, 1:
                begin
                    if (ticks < allowed)
                    begin
                        send_tick();
                        ticks++;
                    end
                end
                2:
                begin
                    b = byte_t'($urandom_range(255));
                    if ((b >= DIGIT_LO && b <= DIGIT_HI) || b == CR_BYTE)
                        b = START_BYTE;
                    send(MODE_BYTE, b);
                end
                3:
                begin
                    // carriage return throws away the digits so far
                    if (crs < 2 && pos > 0)
                    begin
                        send(MODE_BYTE, CR_BYTE);
                        pos = 0;
                        crs++;
                    end
                end
                4:
                    send(MODE_UNUSED, byte_t'($urandom_range(255)));
                default:
                begin
                    send_digit(digit[pos]);
                    pos++;
                end
            endcase
        end
        if (timeout_frame && abandon != 2)
        begin
            while (ticks < ((cur_frame > 0) ? cur_frame : 1))
            begin
                send_tick();
                ticks++;
            end
        end
    endtask

    initial
    begin
        int phase_end;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_TICK;
        rx_byte   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_WAIT_LIMIT;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: ignored items while idle, error codes, carriage return, restart
        send_tick();
        send(MODE_BYTE, START_BYTE);
        send(MODE_UNUSED, 8'hFF);
        send(MODE_START, 8'h00);
        send(MODE_BYTE, START_BYTE);
        send_digit(0);
        send_digit(5);
        send_digit(0);
        send_digit(0);
        send(MODE_START, 8'hFF);
        send(MODE_BYTE, 8'h00);
        send(MODE_BYTE, START_BYTE);
        send_digit(5);
        send(MODE_BYTE, CR_BYTE);
        send_digit(5);
        send_digit(0);
        send_digit(0);
        send_digit(0);
        send(MODE_START, 8'h00);
        send(MODE_START, 8'hFF);
        send(MODE_BYTE, START_BYTE);
        send_digit(9);
        send(MODE_BYTE, START_BYTE);
        send(MODE_BYTE, DIGIT_HI);
        send_digit(9);
        send_digit(9);

        // zero limits: the first tick after arming or after the frame start times out
        settle();
        set_limits('0, '0);
        send(MODE_START, 8'h00);
        send_tick();
        send(MODE_START, 8'hFF);
        send(MODE_BYTE, START_BYTE);
        send_tick();

        // top limits: one full wait timeout with the counter at its ceiling
        settle();
        set_limits(ELAPSED_MAX, ELAPSED_MAX);
        run_measurement(1'b1);
        repeat (6) run_measurement(1'b0);

        for (int p = 0; p < 8; p++)
        begin
            settle();
            if (p == 7)
                set_limits(limit_t'($urandom_range(50, 1)), limit_t'($urandom_range(50, 1)));
            else
                set_limits(wait_tab[p], frame_tab[p]);
            idle_pct  = idle_tab[p % 4];
            stall_pct = stall_tab[p % 4];
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                run_measurement(1'b0);
        end

        settle();
        if (mismatch_count == 0)
            $display("** serial_range_frame_parser: PASSED **");
        else
            $display("** serial_range_frame_parser: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
design/srfp_pkg.sv
design/serial_range_frame_parser.sv
tb/range_result_checker.sv
tb/testbench.sv
